[rtl/pica_pkg.sv]
`default_nettype none

package pica_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 24;
    localparam int SUM_W     = DATA_W + 1;
    localparam int OPA_W     = DATA_W + 3;
    localparam int PROD_W    = OPA_W + GAIN_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = 5;
    localparam int IDX_W     = 3;

    // item commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN_DT = 3'd1;
    localparam logic [IDX_W-1:0] REG_BACKCALC_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_INTEG_LOWER   = 3'd3;
    localparam logic [IDX_W-1:0] REG_INTEG_UPPER   = 3'd4;
    localparam logic [IDX_W-1:0] REG_OUT_LOWER     = 3'd5;
    localparam logic [IDX_W-1:0] REG_OUT_UPPER     = 3'd6;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [GAIN_W-1:0]        t_gain;

    typedef struct packed {
        t_gain prop_gain;
        t_gain integ_gain_dt;
        t_gain backcalc_gain;
        t_word integ_lower;
        t_word integ_upper;
        t_word out_lower;
        t_word out_upper;
    } t_cfg;

endpackage

`default_nettype wire

[rtl/pica_if.sv]
`default_nettype none

interface pica_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [pica_pkg::DATA_W-1:0] error_sample;

    modport source (output valid, output command, output error_sample, input ready);
    modport sink   (input valid, input command, input error_sample, output ready);
endinterface

interface pica_out_if;
    logic                         valid;
    logic                         ready;
    logic signed [pica_pkg::DATA_W-1:0] drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

`default_nettype wire

[rtl/pica_regs.sv]
`default_nettype none

module pica_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pica_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pica_pkg::DATA_W-1:0]   pwdata,
    output logic      [pica_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output pica_pkg::t_cfg                     o_cfg
);

    pica_pkg::t_cfg                 r_cfg;
    logic [pica_pkg::IDX_W-1:0]     w_idx;
    logic                           w_wr;

    assign w_idx  = paddr[pica_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                pica_pkg::REG_PROP_GAIN:     r_cfg.prop_gain     <= pwdata[pica_pkg::GAIN_W-1:0];
                pica_pkg::REG_INTEG_GAIN_DT: r_cfg.integ_gain_dt <= pwdata[pica_pkg::GAIN_W-1:0];
                pica_pkg::REG_BACKCALC_GAIN: r_cfg.backcalc_gain <= pwdata[pica_pkg::GAIN_W-1:0];
                pica_pkg::REG_INTEG_LOWER:   r_cfg.integ_lower   <= pwdata;
                pica_pkg::REG_INTEG_UPPER:   r_cfg.integ_upper   <= pwdata;
                pica_pkg::REG_OUT_LOWER:     r_cfg.out_lower     <= pwdata;
                pica_pkg::REG_OUT_UPPER:     r_cfg.out_upper     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            pica_pkg::REG_PROP_GAIN:     prdata = {8'd0, r_cfg.prop_gain};
            pica_pkg::REG_INTEG_GAIN_DT: prdata = {8'd0, r_cfg.integ_gain_dt};
            pica_pkg::REG_BACKCALC_GAIN: prdata = {8'd0, r_cfg.backcalc_gain};
            pica_pkg::REG_INTEG_LOWER:   prdata = r_cfg.integ_lower;
            pica_pkg::REG_INTEG_UPPER:   prdata = r_cfg.integ_upper;
            pica_pkg::REG_OUT_LOWER:     prdata = r_cfg.out_lower;
            pica_pkg::REG_OUT_UPPER:     prdata = r_cfg.out_upper;
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/pica_mul.sv]
`default_nettype none

// shared signal x gain multiplier, registered product, then round and saturate to q16.16
module pica_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [pica_pkg::OPA_W-1:0]   i_op_a,
    input  wire logic        [pica_pkg::GAIN_W-1:0]  i_op_b,
    output pica_pkg::t_word                          o_rounded
);

    localparam int Q_W = pica_pkg::PROD_W - pica_pkg::FRAC_BITS;

    logic signed [pica_pkg::PROD_W-1:0] r_prod;
    logic signed [pica_pkg::PROD_W-1:0] w_biased;
    logic signed [Q_W-1:0]              w_q;
    logic signed [Q_W-1:0]              w_max;
    logic signed [Q_W-1:0]              w_min;

    always_ff @(posedge i_clk) begin
        r_prod <= pica_pkg::PROD_W'(i_op_a * $signed({1'b0, i_op_b}));
    end

    // round half up, then floor divide by 2^16
    assign w_biased = r_prod + $signed(pica_pkg::PROD_W'(1) <<< (pica_pkg::FRAC_BITS - 1));
    assign w_q      = w_biased[pica_pkg::PROD_W-1:pica_pkg::FRAC_BITS];
    assign w_max    = $signed({{(Q_W-pica_pkg::DATA_W+1){1'b0}}, {(pica_pkg::DATA_W-1){1'b1}}});
    assign w_min    = $signed({{(Q_W-pica_pkg::DATA_W+1){1'b1}}, {(pica_pkg::DATA_W-1){1'b0}}});

    always_comb begin
        if (w_q > w_max) begin
            o_rounded = w_max[pica_pkg::DATA_W-1:0];
        end else if (w_q < w_min) begin
            o_rounded = w_min[pica_pkg::DATA_W-1:0];
        end else begin
            o_rounded = w_q[pica_pkg::DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/pi_controller_back_calc_antiwindup_unit.sv]
// pi controller with back-calculation anti-windup, fixed point
//
// input channel i_cmd_if carries one transaction per control step: command
// update with an error sample (signed q16.16), or command clear. output
// channel o_drv_if returns exactly one drive_value transaction per input
// transaction. gains (unsigned q8.16) and limits (signed q16.16) sit in an
// apb register file at byte addresses 4*index; write them only while idle.
//
// sequencing: a clear gives its result in the cycle after acceptance. an
// update steps through mul_p, mul_i, integ, sum, check and out, and runs
// the back-calculation pass (mul_b, back) before out when the output
// saturates with a nonzero proportional gain. all three gain products go
// through one shared 35x25 multiplier with a registered product, stepped by
// the sequencer below, and the next transaction waits until the update ends.
//
// reset clears the integrator, the registers and the output slot. a result
// waits in the output register while the receiver stalls; a new transaction
// is accepted only once that slot is free or being drained in the same cycle.
`default_nettype none

module pi_controller_back_calc_antiwindup_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    pica_in_if.sink                            i_cmd_if,
    pica_out_if.source                         o_drv_if,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pica_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pica_pkg::DATA_W-1:0]   pwdata,
    output logic      [pica_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int SUM_W = pica_pkg::SUM_W;
    localparam int OPA_W = pica_pkg::OPA_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL_P = 4'd1;   // kp * err into product
    localparam logic [3:0] ST_MUL_I = 4'd2;   // prop ready, ki * err into product
    localparam logic [3:0] ST_INTEG = 4'd3;   // integrator update and clamp
    localparam logic [3:0] ST_SUM   = 4'd4;   // unclamped output sum
    localparam logic [3:0] ST_CHECK = 4'd5;   // saturation test, form clamp error
    localparam logic [3:0] ST_MUL_B = 4'd6;   // back gain * clamp error
    localparam logic [3:0] ST_BACK  = 4'd7;   // integrator correction
    localparam logic [3:0] ST_OUT   = 4'd8;   // final clamp into output slot

    pica_pkg::t_cfg            w_cfg;
    pica_pkg::t_word           w_rounded;

    logic [3:0]                r_state,   n_state;
    logic signed [OPA_W-1:0]   r_opa,     n_opa;
    pica_pkg::t_gain           r_opb,     n_opb;
    pica_pkg::t_word           r_prop,    n_prop;
    pica_pkg::t_word           r_integ,   n_integ;
    logic signed [SUM_W-1:0]   r_sum,     n_sum;
    pica_pkg::t_word           r_acc,     n_acc;
    logic                      r_out_vld, n_out_vld;
    pica_pkg::t_word           r_out,     n_out;

    logic                      w_slot_free;
    logic                      w_in_acc;
    logic signed [SUM_W-1:0]   w_integ_sum;
    logic signed [SUM_W-1:0]   w_back_sum;
    logic signed [SUM_W-1:0]   w_out_sum;
    logic signed [SUM_W-1:0]   w_ol;
    logic signed [SUM_W-1:0]   w_ou;
    logic                      w_sat_hit;
    pica_pkg::t_word           w_sat;

    // lower bound tested first, so with inverted limits a value below lower gives lower
    function automatic pica_pkg::t_word clamp_word(input logic signed [SUM_W-1:0] v,
                                                   input pica_pkg::t_word lo,
                                                   input pica_pkg::t_word hi);
        logic signed [SUM_W-1:0] lo_x;
        logic signed [SUM_W-1:0] hi_x;
        lo_x = {lo[pica_pkg::DATA_W-1], lo};
        hi_x = {hi[pica_pkg::DATA_W-1], hi};
        if (v < lo_x) begin
            return lo;
        end else if (v > hi_x) begin
            return hi;
        end else begin
            return v[pica_pkg::DATA_W-1:0];
        end
    endfunction

    pica_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pica_mul u_mul (
        .i_clk     (i_clk),
        .i_op_a    (r_opa),
        .i_op_b    (r_opb),
        .o_rounded (w_rounded)
    );

    // output slot frees when empty or drained this cycle
    assign w_slot_free = !r_out_vld || o_drv_if.ready;
    assign i_cmd_if.ready = (r_state == ST_IDLE) && w_slot_free;
    assign w_in_acc = i_cmd_if.valid && i_cmd_if.ready;

    assign o_drv_if.valid       = r_out_vld;
    assign o_drv_if.drive_value = r_out;

    // full-width sums, no wrap before clamping
    assign w_integ_sum = {r_acc[pica_pkg::DATA_W-1], r_acc}
                       + {w_rounded[pica_pkg::DATA_W-1], w_rounded};
    assign w_back_sum  = {r_integ[pica_pkg::DATA_W-1], r_integ}
                       + {w_rounded[pica_pkg::DATA_W-1], w_rounded};
    assign w_out_sum   = {r_prop[pica_pkg::DATA_W-1], r_prop}
                       + {r_integ[pica_pkg::DATA_W-1], r_integ};

    assign w_ol = {w_cfg.out_lower[pica_pkg::DATA_W-1], w_cfg.out_lower};
    assign w_ou = {w_cfg.out_upper[pica_pkg::DATA_W-1], w_cfg.out_upper};
    assign w_sat_hit = ((r_sum > w_ou) || (r_sum < w_ol)) && (w_cfg.prop_gain != '0);
    assign w_sat     = clamp_word(r_sum, w_cfg.out_lower, w_cfg.out_upper);

    always_comb begin
        n_state   = r_state;
        n_opa     = r_opa;
        n_opb     = r_opb;
        n_prop    = r_prop;
        n_integ   = r_integ;
        n_sum     = r_sum;
        n_acc     = r_acc;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_drv_if.ready;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_cmd_if.command == pica_pkg::CMD_CLEAR) begin
                        n_acc     = '0;
                        n_out     = '0;
                        n_out_vld = 1'b1;
                    end else begin
                        n_opa   = OPA_W'(i_cmd_if.error_sample);
                        n_opb   = w_cfg.prop_gain;
                        n_state = ST_MUL_P;
                    end
                end
            end
            ST_MUL_P: begin
                n_opb   = w_cfg.integ_gain_dt;
                n_state = ST_MUL_I;
            end
            ST_MUL_I: begin
                n_prop  = w_rounded;
                n_state = ST_INTEG;
            end
            ST_INTEG: begin
                n_integ = clamp_word(w_integ_sum, w_cfg.integ_lower, w_cfg.integ_upper);
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_sum   = w_out_sum;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_sat_hit) begin
                    // clamped minus unclamped sum, at most 34 bits
                    n_opa   = OPA_W'(w_sat) - OPA_W'(r_sum);
                    n_opb   = w_cfg.backcalc_gain;
                    n_state = ST_MUL_B;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_MUL_B: begin
                n_state = ST_BACK;
            end
            ST_BACK: begin
                n_integ = clamp_word(w_back_sum, w_cfg.integ_lower, w_cfg.integ_upper);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // hold here while the receiver stalls the previous result
                if (w_slot_free) begin
                    n_acc     = r_integ;
                    n_out     = clamp_word(w_out_sum, w_cfg.out_lower, w_cfg.out_upper);
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_acc     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_prop  <= n_prop;
        r_integ <= n_integ;
        r_sum   <= n_sum;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

[rtl/pica_checker.sv]
`default_nettype none

module pica_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_in_command,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [pica_pkg::DATA_W-1:0] i_out_value,
    input wire logic                        i_pready
);

    // a clear returns zero in the next cycle
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_command == pica_pkg::CMD_CLEAR)
        |=> (i_out_valid && i_out_value == '0))
        else $error("clear did not return zero");

    // an update keeps the input closed through the mul_p and mul_i states
    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_command == pica_pkg::CMD_UPDATE)
        |=> !i_in_ready ##1 !i_in_ready)
        else $error("input reopened during an update");

    // no new transaction while a stalled result still occupies the slot
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input accepted over a stalled result");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_value)))
        else $error("stalled result dropped or changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready low");

endmodule

bind pi_controller_back_calc_antiwindup_unit pica_checker u_pica_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd_if.valid),
    .i_in_ready   (i_cmd_if.ready),
    .i_in_command (i_cmd_if.command),
    .i_out_valid  (o_drv_if.valid),
    .i_out_ready  (o_drv_if.ready),
    .i_out_value  (o_drv_if.drive_value),
    .i_pready     (pready)
);

`default_nettype wire
